// ===== hdl/res_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// res_pkg
// Shared types and constants of the refresh entry scheduler.
// ----------------------------------------------------------------------------
package res_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int SEL_W   = 5;

    localparam logic [31:0] RESET_INTERVAL = 32'd900000;
    localparam logic [31:0] RESET_RETRY    = 32'd60000;
    localparam logic [31:0] RESET_GAP      = 32'd5000;

    localparam logic [2:0] ACT_START     = 3'd0;
    localparam logic [2:0] ACT_OK        = 3'd1;
    localparam logic [2:0] ACT_FAIL      = 3'd2;
    localparam logic [2:0] ACT_SET_ENTRY = 3'd3;
    localparam logic [2:0] ACT_SET_VIEW  = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_HELD    = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] REG_INTERVAL = 2'd0;
    localparam logic [1:0] REG_RETRY    = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic        link_up;
        logic        allow_start;
        logic [4:0]  entry_sel;
        logic        enable_bit;
    } req_word_t;

    typedef struct packed {
        logic       granted;
        logic [4:0] grant_entry;
        logic [1:0] status;
    } rsp_word_t;

    // controller -> datapath
    typedef struct packed {
        logic             load;       // capture request word
        logic             scan_clr;   // restart scan counter
        logic             scan_step;  // advance scan by one slot
        logic             pass_any;   // 0 invalid-only pass, 1 any-due pass
        logic             do_simple;  // execute non-start action
        logic             do_abort;   // link-down abort
        logic             do_grant;   // grant found slot / view slot
        logic             grant_view;
    } res_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic action_start;
        logic link_up;
        logic held;       // busy / not allowed / gap
        logic hit;        // current scanned slot qualifies
        logic scan_last;  // current slot is last of the pass
        logic view_hit;
    } res_sts_t;

endpackage
`default_nettype wire

// ===== hdl/res_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// res_stream_if
// Valid/ready channel carrying one word of type word_t.
// ----------------------------------------------------------------------------
interface res_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/res_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// res_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface res_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/res_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// res_ctrl
// Sequencer: accept, decode, invalid pass, view check, any-due pass, grant, respond.
// ----------------------------------------------------------------------------
module res_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire res_pkg::res_sts_t sts,
    output res_pkg::res_cmd_t      cmd,
    output logic                   rsp_none
);
    import res_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_SCAN_INV, S_VIEW, S_SCAN_ANY, S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   none_reg, none_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign rsp_none  = none_reg;

    always_comb
    begin
        state_next = state_reg;
        none_next  = none_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                none_next = 1'b0;
                cmd.scan_clr = 1'b1;
                if (!sts.action_start)
                begin
                    cmd.do_simple = 1'b1;
                    state_next    = S_RESP;
                end
                else if (!sts.link_up)
                begin
                    cmd.do_abort = 1'b1;
                    state_next   = S_RESP;
                end
                else if (sts.held)
                    state_next = S_RESP;
                else
                    state_next = S_SCAN_INV;
            end
            S_SCAN_INV:
            begin
                if (sts.hit)
                begin
                    cmd.do_grant = 1'b1;
                    state_next   = S_RESP;
                end
                else if (sts.scan_last)
                    state_next = S_VIEW;
                else
                    cmd.scan_step = 1'b1;
            end
            S_VIEW:
            begin
                cmd.scan_clr = 1'b1;
                cmd.pass_any = 1'b1;
                if (sts.view_hit)
                begin
                    cmd.do_grant   = 1'b1;
                    cmd.grant_view = 1'b1;
                    state_next     = S_RESP;
                end
                else
                    state_next = S_SCAN_ANY;
            end
            S_SCAN_ANY:
            begin
                cmd.pass_any = 1'b1;
                if (sts.hit)
                begin
                    cmd.do_grant = 1'b1;
                    state_next   = S_RESP;
                end
                else if (sts.scan_last)
                begin
                    none_next  = 1'b1;
                    state_next = S_RESP;
                end
                else
                    cmd.scan_step = 1'b1;
            end
            S_RESP:
            begin
                cmd.pass_any = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            none_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            none_reg  <= none_next;
        end
    end

    a_grant_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_grant |=> state_reg == S_RESP)
        else $error("grant not followed by response");
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("response dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("accept while working");
endmodule
`default_nettype wire

// ===== hdl/res_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// res_datapath
// Slot table, scheduler registers, scan counter and due check.
// ----------------------------------------------------------------------------
module res_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire res_pkg::req_word_t req,
    input  wire res_pkg::res_cmd_t  cmd,
    input  wire logic               rsp_none,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output res_pkg::res_sts_t       sts,
    output res_pkg::rsp_word_t      rsp
);
    import res_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [31:0] interval_reg, retry_reg, gap_reg;
    req_word_t   req_reg;
    logic [ENTRIES-1:0] en_reg, val_reg;
    logic [31:0] last_reg  [ENTRIES];
    logic [31:0] retry_t_reg [ENTRIES];
    logic [IDX_W-1:0] rr_reg, cnt_reg, busy_entry_reg, view_reg, gnt_reg;
    logic [31:0] next_start_reg;
    logic        busy_reg, view_on_reg, granted_reg;
    logic [1:0]  status_reg;
    logic        pass_any_reg;

    logic [IDX_W-1:0] slot, sel_idx;
    logic             sel_in_range;
    logic             hit, view_hit;

    // slot under test: rr pointer + counter mod ENTRIES
    always_comb
    begin
        logic [IDX_W:0] sum;
        sum = {1'b0, rr_reg} + {1'b0, cnt_reg};
        if (sum >= (IDX_W+1)'(ENTRIES))
            sum = sum - (IDX_W+1)'(ENTRIES);
        slot = sum[IDX_W-1:0];
    end

    function automatic logic due(input logic [31:0] now, input logic [31:0] rt,
                                 input logic v, input logic [31:0] lt,
                                 input logic [31:0] iv);
        logic [31:0] age;
        age = now - lt;
        due = (now >= rt) && (!v || (age >= iv));
    endfunction

    assign hit = en_reg[slot] && (pass_any_reg || !val_reg[slot]) &&
                 due(req_reg.now_ms, retry_t_reg[slot], val_reg[slot],
                     last_reg[slot], interval_reg);
    assign view_hit = view_on_reg && en_reg[view_reg] &&
                 due(req_reg.now_ms, retry_t_reg[view_reg], val_reg[view_reg],
                     last_reg[view_reg], interval_reg);

    assign sel_idx      = req_reg.entry_sel[IDX_W-1:0];
    assign sel_in_range = (32'(req_reg.entry_sel) < 32'(ENTRIES));

    assign sts.action_start = (req_reg.action == ACT_START);
    assign sts.link_up      = req_reg.link_up;
    assign sts.held         = busy_reg || !req_reg.allow_start ||
                              (req_reg.now_ms < next_start_reg);
    assign sts.hit          = hit;
    assign sts.scan_last    = (cnt_reg == LAST_IDX);
    assign sts.view_hit     = view_hit;

    assign rsp.granted     = granted_reg;
    assign rsp.grant_entry = granted_reg ? 5'(gnt_reg) : 5'd0;
    assign rsp.status      = rsp_none ? ST_NONE : status_reg;

    // table storage and scheduler registers, all cleared or set to defaults on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg   <= RESET_INTERVAL;
            retry_reg      <= RESET_RETRY;
            gap_reg        <= RESET_GAP;
            en_reg         <= '0;
            val_reg        <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                last_reg[i]    <= '0;
                retry_t_reg[i] <= '0;
            end
            rr_reg         <= '0;
            cnt_reg        <= '0;
            busy_entry_reg <= '0;
            view_reg       <= '0;
            gnt_reg        <= '0;
            next_start_reg <= '0;
            busy_reg       <= 1'b0;
            view_on_reg    <= 1'b0;
            granted_reg    <= 1'b0;
            status_reg     <= ST_IGNORED;
            pass_any_reg   <= 1'b0;
            req_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INTERVAL: interval_reg <= cfg_data;
                    REG_RETRY:    retry_reg    <= cfg_data;
                    REG_GAP:      gap_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                req_reg     <= req;
                granted_reg <= 1'b0;
                status_reg  <= ST_IGNORED;
            end
            pass_any_reg <= cmd.pass_any;
            if (cmd.scan_clr)
                cnt_reg <= '0;
            else if (cmd.scan_step)
                cnt_reg <= cnt_reg + 1'b1;

            if (cmd.do_abort)
            begin
                status_reg <= ST_HELD;
                if (busy_reg)
                begin
                    retry_t_reg[busy_entry_reg] <= req_reg.now_ms + retry_reg;
                    next_start_reg <= req_reg.now_ms + gap_reg;
                    busy_reg       <= 1'b0;
                    busy_entry_reg <= '0;
                end
            end
            else if (cmd.scan_clr && !cmd.pass_any && sts.action_start &&
                     req_reg.link_up && sts.held)
                status_reg <= ST_HELD;

            if (cmd.do_grant)
            begin
                logic [IDX_W-1:0] g;
                g = cmd.grant_view ? view_reg : slot;
                if (!cmd.grant_view)
                    rr_reg <= (slot == LAST_IDX) ? '0 : slot + 1'b1;
                busy_reg       <= 1'b1;
                busy_entry_reg <= g;
                gnt_reg        <= g;
                next_start_reg <= req_reg.now_ms + gap_reg;
                granted_reg    <= 1'b1;
                status_reg     <= ST_DONE;
            end

            if (cmd.do_simple)
            begin
                case (req_reg.action)
                    ACT_OK, ACT_FAIL:
                    begin
                        if (busy_reg)
                        begin
                            if (req_reg.action == ACT_OK)
                            begin
                                val_reg[busy_entry_reg]  <= 1'b1;
                                last_reg[busy_entry_reg] <= req_reg.now_ms;
                            end
                            else
                                retry_t_reg[busy_entry_reg] <=
                                    req_reg.now_ms + retry_reg;
                            next_start_reg <= req_reg.now_ms + gap_reg;
                            busy_reg       <= 1'b0;
                            busy_entry_reg <= '0;
                            status_reg     <= ST_DONE;
                        end
                    end
                    ACT_SET_ENTRY:
                    begin
                        if (sel_in_range)
                        begin
                            en_reg[sel_idx] <= req_reg.enable_bit;
                            status_reg      <= ST_DONE;
                        end
                    end
                    ACT_SET_VIEW:
                    begin
                        if (!req_reg.enable_bit)
                        begin
                            view_on_reg <= 1'b0;
                            view_reg    <= '0;
                            status_reg  <= ST_DONE;
                        end
                        else if (sel_in_range)
                        begin
                            view_on_reg <= 1'b1;
                            view_reg    <= sel_idx;
                            status_reg  <= ST_DONE;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_busy_grant: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_grant |=> busy_reg && granted_reg)
        else $error("grant did not set busy");
    a_view_owned: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant_view |-> view_on_reg)
        else $error("view grant with view off");
    a_grant_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_grant |-> !cmd.do_simple && !cmd.do_abort)
        else $error("overlapping commands");
endmodule
`default_nettype wire

// ===== hdl/refresh_entry_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// refresh_entry_scheduler_unit
// Refresh scheduler over a 32-slot table with one outstanding refresh.
// ----------------------------------------------------------------------------
// Usage:
//   req  : request word (action, now_ms, link_up, allow_start, entry_sel,
//          enable_bit), valid/ready. Taken only when the unit is idle.
//   rsp  : response word (granted, grant_entry, status), valid/ready.
//   cfg  : register writes, index 0 interval, 1 retry delay, 2 start gap;
//          always ready, write only while idle.
// Sequence: non-start actions and held-off starts pass through accept,
//   decode and response. A start that scans adds the invalid pass and, if
//   that finds no slot, the view check and the any-due pass, one slot
//   checked per cycle by the due check.
// Throughput: one word at a time; the next word is taken the cycle after
//   the response is taken.
// Reset: table, marks, pointers cleared, view off, registers to defaults.
// Stall: the response is held until rsp.ready; no new word is taken meanwhile.
// ----------------------------------------------------------------------------
module refresh_entry_scheduler_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    res_stream_if.sink   req,
    res_stream_if.source rsp,
    res_cfg_if.sink      cfg
);
    import res_pkg::*;

    res_cmd_t  cmd;
    res_sts_t  sts;
    logic      rsp_none;
    rsp_word_t rsp_word;

    assign cfg.ready = 1'b1;

    res_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd),
        .rsp_none  (rsp_none)
    );

    res_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.data),
        .cmd       (cmd),
        .rsp_none  (rsp_none),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sts       (sts),
        .rsp       (rsp_word)
    );

    assign rsp.data = rsp_word;
endmodule
`default_nettype wire
